FILE: hdl/pcn_pkg.sv
`default_nettype none

package pcn_pkg;

  // Codes carried on the input tuser bit.
  localparam logic KIND_GEOM  = 1'b0;
  localparam logic KIND_SCORE = 1'b1;

  // Fixed field widths.
  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int CLS_ID_W = 3;
  localparam int THR_W = 16;
  localparam int NCLS_REG_W = 4;
  localparam int AREA_W = 32;
  localparam int IN_TDATA_W = 88;
  localparam int OUT_TDATA_W = 16;
  localparam int MASK_W = 8;
  localparam int OUT_IDX_W = 6;

  // Configuration register indexes.
  localparam logic REG_IOU_THRESHOLD  = 1'b0;
  localparam logic REG_CLASSES_IN_USE = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;
  localparam logic [NCLS_REG_W-1:0] NCLS_RESET = 4'd8;

  // One stored box: center and size, unsigned Q0.16.
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } geom_t;

endpackage

`default_nettype wire

FILE: hdl/pcn_iou.sv
`default_nettype none

// Pipelined overlap test: does box b overlap box a by more than the threshold?
// Four register stages; the final compare sits after the last one.
module pcn_iou import pcn_pkg::*; #(
  parameter int TAG_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire geom_t              a_geom,
  input  wire logic [AREA_W-1:0]  a_area,
  input  wire logic [THR_W-1:0]   thr,
  input  wire geom_t              b_geom,
  input  wire logic [TAG_W-1:0]   in_tag,
  output logic                    out_valid,
  output logic                    exceed,
  output geom_t                   out_geom,
  output logic [AREA_W-1:0]       out_area,
  output logic [TAG_W-1:0]        out_tag,
  output logic                    busy
);

  typedef logic signed [19:0] edge_t;

  function automatic edge_t low_side(input logic [15:0] c, input logic [15:0] w);
    low_side = $signed({3'b000, c, 1'b0}) - $signed({4'b0000, w});
  endfunction

  function automatic edge_t high_side(input logic [15:0] c, input logic [15:0] w);
    high_side = $signed({3'b000, c, 1'b0}) + $signed({4'b0000, w});
  endfunction

  // Doubled overlap per axis; negative means the boxes are apart.
  edge_t lxa, lxb, rxa, rxb, lya, lyb, rya, ryb, ox, oy;
  always_comb begin
    lxa = low_side(a_geom.cx, a_geom.w);
    lxb = low_side(b_geom.cx, b_geom.w);
    rxa = high_side(a_geom.cx, a_geom.w);
    rxb = high_side(b_geom.cx, b_geom.w);
    lya = low_side(a_geom.cy, a_geom.h);
    lyb = low_side(b_geom.cy, b_geom.h);
    rya = high_side(a_geom.cy, a_geom.h);
    ryb = high_side(b_geom.cy, b_geom.h);
    ox = ((rxa < rxb) ? rxa : rxb) - ((lxa > lxb) ? lxa : lxb);
    oy = ((rya < ryb) ? rya : ryb) - ((lya > lyb) ? lya : lyb);
  end

  logic              va_r, vb_r, vc_r, vd_r;
  logic [17:0]       ox_r, oy_r;
  logic              apart_r;
  geom_t             ga_r, gb_r, gc_r, gd_r;
  logic [TAG_W-1:0]  ta_r, tb_r, tc_r, td_r;
  logic [35:0]       i4b_r, i4c_r, i4d_r;
  logic [AREA_W-1:0] sb_r, sc_r, sd_r;
  logic [35:0]       u4_r;
  logic [33:0]       phi_r, plo_r;
  logic [35:0]       u4_sum;

  assign u4_sum = ({2'b00, a_area, 2'b00} + {2'b00, sb_r, 2'b00}) - i4b_r;

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  // Data path: overlaps, products, union, threshold partial products.
  always_ff @(posedge clk) begin
    ox_r    <= ox[17:0];
    oy_r    <= oy[17:0];
    apart_r <= ox[19] | oy[19];
    ga_r    <= b_geom;
    ta_r    <= in_tag;

    i4b_r <= apart_r ? 36'd0 : (36'(ox_r) * 36'(oy_r));
    sb_r  <= AREA_W'(32'(ga_r.w) * 32'(ga_r.h));
    gb_r  <= ga_r;
    tb_r  <= ta_r;

    u4_r  <= u4_sum;
    i4c_r <= i4b_r;
    sc_r  <= sb_r;
    gc_r  <= gb_r;
    tc_r  <= tb_r;

    phi_r <= 34'(thr) * 34'(u4_r[35:18]);
    plo_r <= 34'(thr) * 34'(u4_r[17:0]);
    i4d_r <= i4c_r;
    sd_r  <= sc_r;
    gd_r  <= gc_r;
    td_r  <= tc_r;
  end

  // Final compare: 65536 * I4 > threshold * U4.
  logic [52:0] rhs;
  logic [52:0] lhs;
  assign rhs = {1'b0, phi_r, 18'd0} + 53'(plo_r);
  assign lhs = {1'b0, i4d_r, 16'd0};

  assign exceed    = lhs > rhs;
  assign out_valid = vd_r;
  assign out_geom  = gd_r;
  assign out_area  = sd_r;
  assign out_tag   = td_r;
  assign busy      = va_r | vb_r | vc_r | vd_r;

endmodule

`default_nettype wire

FILE: hdl/per_class_greedy_nms.sv
// Per-class greedy non-maximum suppression.
// Input stream: each transfer is one item. in_tuser = 0 carries a box geometry
// and starts the next box; in_tuser = 1 carries one class score for the
// current box. in_tlast marks the final item of a load and starts suppression.
// Loading takes one transfer per cycle; in_tready is high only while loading.
// Suppression then runs per class in rounds: each round scans all loaded boxes
// through the overlap pipeline, suppresses boxes that overlap the box chosen
// last round and picks the next highest surviving score. A class takes up to
// (n + 1) rounds; the pass is bound by the single read port of the score and
// geometry memories.
// Output stream: one transfer per loaded box, in load order, with its index
// and surviving class mask; out_tlast marks the last box. Each result goes
// through ST_OUT_RD, ST_OUT_LAT, ST_OUT_WAIT; while out_tready is low the
// result is held and nothing else moves. After the last result the block
// loads again. Reset empties the load and restores the configuration
// registers; the memories need no clearing because a new box clears its row.
`default_nettype none

module per_class_greedy_nms import pcn_pkg::*; #(
  parameter int MAX_BOXES   = 64,
  parameter int MAX_CLASSES = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // center_x, center_y, box_width, box_height, class_id, score, zero pad
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,
  // kind
  input  wire logic                    in_tuser,
  input  wire logic                    in_tlast,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // box_index, keep_mask, zero pad
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  output logic                         out_tlast,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [THR_W-1:0]        cfg_wdata
);

  localparam int AW    = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int NC_W  = $clog2(MAX_CLASSES + 1);
  localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int TAG_W = 1 + SCORE_W + AW;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SCAN, ST_OUT_RD, ST_OUT_LAT, ST_OUT_WAIT
  } state_t;

  typedef logic [MAX_CLASSES-1:0][SCORE_W-1:0] row_t;

  state_t state_r;

  // Input fields.
  geom_t               in_geom;
  logic [CLS_ID_W-1:0] in_cls;
  logic [SCORE_W-1:0]  in_score;
  assign in_geom.cx = in_tdata[15:0];
  assign in_geom.cy = in_tdata[31:16];
  assign in_geom.w  = in_tdata[47:32];
  assign in_geom.h  = in_tdata[63:48];
  assign in_cls     = in_tdata[66:64];
  assign in_score   = in_tdata[82:67];

  logic [THR_W-1:0]      thr_r;
  logic [NCLS_REG_W-1:0] cls_r;
  logic [NC_W-1:0]       ncls;
  assign ncls = (32'(cls_r) > MAX_CLASSES) ? NC_W'(MAX_CLASSES) : NC_W'(cls_r);

  logic [CNT_W-1:0] box_cnt_r, box_cnt_nxt;
  logic [CNT_W-1:0] scan_j_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [NC_W-1:0]  k_r;
  logic [CW-1:0]    k_lane;
  assign k_lane = k_r[CW-1:0];

  // Current suppressor and best candidate for the next round.
  logic               cur_v_r;
  geom_t              a_geom_r;
  logic [AREA_W-1:0]  a_area_r;
  logic [SCORE_W-1:0] a_score_r;
  logic [AW-1:0]      a_idx_r;
  logic               best_v_r;
  geom_t              best_geom_r;
  logic [AREA_W-1:0]  best_area_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [AW-1:0]      best_idx_r;

  logic          v1_r;
  logic [AW-1:0] idx1_r;

  logic out_tvalid_r, out_tlast_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Load-side decode.
  logic in_xfer, geom_ok, score_ok;
  assign in_tready = (state_r == ST_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign geom_ok   = in_xfer && (in_tuser == KIND_GEOM) && (32'(box_cnt_r) < MAX_BOXES);
  assign score_ok  = in_xfer && (in_tuser == KIND_SCORE) && (box_cnt_r != '0) &&
                     (32'(in_cls) < MAX_CLASSES);
  assign box_cnt_nxt = geom_ok ? box_cnt_r + 1'b1 : box_cnt_r;

  // Memories: box geometry and score rows, one row per box.
  geom_t geom_mem [MAX_BOXES];
  row_t  score_mem [MAX_BOXES];
  geom_t geom_q;
  row_t  row_q;
  logic [AW-1:0] rd_addr;
  assign rd_addr = (state_r == ST_SCAN) ? scan_j_r[AW-1:0] : out_cnt_r[AW-1:0];

  // Overlap pipeline results.
  logic               iou_valid, iou_exceed, iou_busy;
  geom_t              iou_geom;
  logic [AREA_W-1:0]  iou_area;
  logic [TAG_W-1:0]   iou_tag, tag1;
  logic               t_cand;
  logic [SCORE_W-1:0] t_score;
  logic [AW-1:0]      t_idx;
  assign {t_cand, t_score, t_idx} = iou_tag;

  logic suppress;
  assign suppress = iou_valid && cur_v_r && t_cand && iou_exceed;

  // Score memory write port: load writes or suppression clears.
  logic [AW-1:0]          sw_addr;
  logic [MAX_CLASSES-1:0] sw_lane_we;
  logic [SCORE_W-1:0]     sw_data;
  always_comb begin
    sw_addr    = box_cnt_r[AW-1:0];
    sw_lane_we = '0;
    sw_data    = '0;
    if (state_r == ST_SCAN) begin
      sw_addr = t_idx;
      for (int l = 0; l < MAX_CLASSES; l++) begin
        sw_lane_we[l] = suppress && (32'(k_lane) == l);
      end
    end else if (geom_ok) begin
      sw_lane_we = '1;
    end else if (score_ok) begin
      sw_addr = AW'(box_cnt_r - 1'b1);
      sw_data = in_score;
      for (int l = 0; l < MAX_CLASSES; l++) begin
        sw_lane_we[l] = (32'(in_cls) == l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (geom_ok) begin
      geom_mem[box_cnt_r[AW-1:0]] <= in_geom;
    end
    geom_q <= geom_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < MAX_CLASSES; l++) begin
      if (sw_lane_we[l]) begin
        score_mem[sw_addr][l] <= sw_data;
      end
    end
    row_q <= score_mem[rd_addr];
  end

  // Candidate: nonzero and ordered after the current suppressor.
  logic [SCORE_W-1:0] s1;
  logic               cand1;
  assign s1 = row_q[k_lane];
  assign cand1 = (s1 != '0) && (!cur_v_r || (s1 < a_score_r) ||
                 ((s1 == a_score_r) && (idx1_r > a_idx_r)));
  assign tag1 = {cand1, s1, idx1_r};

  pcn_iou #(.TAG_W(TAG_W)) u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .a_geom    (a_geom_r),
    .a_area    (a_area_r),
    .thr       (thr_r),
    .b_geom    (geom_q),
    .in_tag    (tag1),
    .out_valid (iou_valid),
    .exceed    (iou_exceed),
    .out_geom  (iou_geom),
    .out_area  (iou_area),
    .out_tag   (iou_tag),
    .busy      (iou_busy)
  );

  logic issue, round_done;
  assign issue      = (state_r == ST_SCAN) && (scan_j_r < box_cnt_r);
  assign round_done = (state_r == ST_SCAN) && (scan_j_r == box_cnt_r) && !v1_r && !iou_busy;

  // Keep mask of the row being read out.
  logic [MASK_W-1:0] mask;
  always_comb begin
    mask = '0;
    for (int l = 0; l < MASK_W; l++) begin
      if (l < MAX_CLASSES) begin
        mask[l] = (row_q[l] != '0);
      end
    end
  end

  // Control: state, counters, round bookkeeping and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      thr_r        <= THR_RESET;
      cls_r        <= NCLS_RESET;
      box_cnt_r    <= '0;
      scan_j_r     <= '0;
      out_cnt_r    <= '0;
      k_r          <= '0;
      cur_v_r      <= 1'b0;
      best_v_r     <= 1'b0;
      v1_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_tlast_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IOU_THRESHOLD:  thr_r <= cfg_wdata;
          REG_CLASSES_IN_USE: cls_r <= cfg_wdata[NCLS_REG_W-1:0];
          default: ;
        endcase
      end

      v1_r   <= issue;
      idx1_r <= scan_j_r[AW-1:0];

      unique case (state_r)
        ST_LOAD: begin
          box_cnt_r <= box_cnt_nxt;
          if (in_xfer && in_tlast && (box_cnt_nxt != '0)) begin
            scan_j_r  <= '0;
            out_cnt_r <= '0;
            k_r       <= '0;
            cur_v_r   <= 1'b0;
            best_v_r  <= 1'b0;
            state_r   <= (ncls == '0) ? ST_OUT_RD : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_j_r <= scan_j_r + 1'b1;
          end
          if (iou_valid && t_cand && !suppress &&
              (!best_v_r || (t_score > best_score_r))) begin
            best_v_r     <= 1'b1;
            best_geom_r  <= iou_geom;
            best_area_r  <= iou_area;
            best_score_r <= t_score;
            best_idx_r   <= t_idx;
          end
          if (round_done) begin
            scan_j_r <= '0;
            best_v_r <= 1'b0;
            if (best_v_r) begin
              cur_v_r   <= 1'b1;
              a_geom_r  <= best_geom_r;
              a_area_r  <= best_area_r;
              a_score_r <= best_score_r;
              a_idx_r   <= best_idx_r;
            end else begin
              cur_v_r <= 1'b0;
              if (NC_W'(k_r + 1'b1) == ncls) begin
                state_r <= ST_OUT_RD;
              end else begin
                k_r <= k_r + 1'b1;
              end
            end
          end
        end
        ST_OUT_RD: begin
          state_r <= ST_OUT_LAT;
        end
        ST_OUT_LAT: begin
          out_tvalid_r <= 1'b1;
          out_tdata_r  <= {2'b00, mask, OUT_IDX_W'(out_cnt_r)};
          out_tlast_r  <= (out_cnt_r == CNT_W'(box_cnt_r - 1'b1));
          state_r      <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            if (out_tlast_r) begin
              box_cnt_r <= '0;
              state_r   <= ST_LOAD;
            end else begin
              out_cnt_r <= out_cnt_r + 1'b1;
              state_r   <= ST_OUT_RD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

FILE: hdl/pcn_checker.sv
`default_nettype none

module pcn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [87:0] in_tdata,
  input wire logic        in_tuser,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_we,
  input wire logic        cfg_index,
  input wire logic [15:0] cfg_wdata
);

  // The block either loads or emits results, never both at once.
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is offered");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed under stall");

  // The final result of a load returns the block to loading.
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("block did not resume loading");

  // An item that does not end the load keeps the load going.
  a_load_go_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("loading stopped without last");

endmodule

bind per_class_greedy_nms pcn_checker u_pcn_checker (.*);

`default_nettype wire
